/* design/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types and constants of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned NUM_REGS   = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_STEPS  = 41;  // quotient bits below the saturation limit
  localparam int unsigned UN_W       = 86;  // dividend magnitude
  localparam int unsigned UD_W       = 57;  // divisor magnitude
  localparam int unsigned PQ_W       = 42;  // signed uncorrected pressure
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [PQ_W-1:0] PQ_LIMIT = 42'h100_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_T1_T2 = 3'd0,
    REG_T3_P1 = 3'd1,
    REG_P2_P3 = 3'd2,
    REG_P4_P5 = 3'd3,
    REG_P6_P7 = 3'd4,
    REG_P8_P9 = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi_c;
    logic [31:0]        pressure_q24_8;
    logic               divide_fault;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coeff_t;

  // Item handed from the front to the back through the queue.
  typedef struct packed {
    logic signed [15:0] temp;
    logic [UN_W-1:0]    un;
    logic [UD_W-1:0]    ud;
    logic               neg;
    logic               fault;
  } fifo_item_t;

  typedef struct packed {
    logic [UD_W-1:0]      rem;
    logic [DIV_STEPS-1:0] unl;
    logic [DIV_STEPS-1:0] q;
    logic [UD_W-1:0]      ud;
    logic                 neg;
    logic                 ovf;
    logic                 fault;
    logic signed [15:0]   temp;
  } div_stage_t;

  typedef struct packed {
    logic signed [PQ_W-1:0] pq;
    logic                   fault;
    logic signed [15:0]     temp;
  } pq_item_t;

endpackage

/* design/bsc_front.sv */
// ----------------------------------------------------------------------------
// Barometric compensation front end
// Temperature polynomial, pressure numerator and divisor, signs split off.
// ----------------------------------------------------------------------------
module bsc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  bsc_pkg::in_item_t in_i,
  input  bsc_pkg::coeff_t   coeff_i,
  output logic              push_o,
  output bsc_pkg::fifo_item_t item_o
);

  logic [8:0] v_q;

  logic signed [20:0] d_q, d_d;
  logic [19:0]        adcp1_q, adcp2_q, adcp3_q, adcp4_q, adcp5_q, adcp6_q;
  logic signed [36:0] dt2_q, dt2_d;
  logic signed [41:0] dsq_q, dsq_d;
  logic signed [58:0] n_q, n_d;
  logic signed [61:0] n5;
  logic signed [19:0] tq;
  logic signed [24:0] tf;
  logic               rnd;
  logic signed [15:0] temp4_q, temp4_d, temp5_q, temp6_q, temp7_q, temp8_q;
  logic signed [25:0] a4_q, a4_d, a5_q;
  logic signed [51:0] aa_q, aa_d;
  logic signed [41:0] ap5_q, ap5_d, ap2_q, ap2_d, ap3_q, ap3_d;
  logic signed [63:0] e_q, e_d, dd_q, dd_d, f_q, f_d;
  logic signed [21:0] pr;
  logic signed [50:0] mlo_q, mlo_d;
  logic signed [49:0] mhi_q, mhi_d;
  logic signed [82:0] vfull;
  logic signed [57:0] var1q_q, var1q_d;
  logic signed [56:0] fmlo_q, fmlo_d;
  logic signed [55:0] fmhi_q, fmhi_d;
  logic signed [87:0] num;
  bsc_pkg::fifo_item_t item_q, item_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[7:0], accept_i};
    end
  end

  always_comb begin
    d_d   = $signed({1'b0, in_i.raw_temperature}) - $signed({1'b0, coeff_i.t1, 4'b0000});
    dt2_d = d_q * $signed(coeff_i.t2);
    dsq_d = d_q * d_q;
    n_d   = (dt2_q <<< 20) + dsq_q * $signed(coeff_i.t3);

    n5  = n_q + (n_q <<< 2);
    tq  = n5[61:42];
    if (tq > 20'sd32767) begin
      temp4_d = 16'sh7fff;
    end else if (tq < -20'sd32768) begin
      temp4_d = 16'sh8000;
    end else begin
      temp4_d = tq[15:0];
    end
    // Fine temperature truncates toward zero.
    tf   = n_q[58:34];
    rnd  = n_q[58] && (n_q[33:0] != 34'd0);
    a4_d = $signed({tf[24], tf}) + $signed({25'd0, rnd}) - 26'sd128000;

    aa_d  = a4_q * a4_q;
    ap5_d = a4_q * $signed(coeff_i.p5);
    ap2_d = a4_q * $signed(coeff_i.p2);
    ap3_d = a4_q * $signed(coeff_i.p3);

    e_d  = aa_q * $signed(coeff_i.p6) + (ap5_q <<< 17) + ($signed(coeff_i.p4) <<< 35);
    dd_d = 64'sh0080_0000_0000_0000 + ap3_q * a5_q + (ap2_q <<< 20);

    pr    = 22'sd1048576 - $signed({2'b00, adcp6_q});
    f_d   = (pr <<< 31) - e_q;
    mlo_d = $signed({1'b0, coeff_i.p1}) * $signed({1'b0, dd_q[31:0]});
    mhi_d = $signed({1'b0, coeff_i.p1}) * $signed(dd_q[63:32]);

    vfull   = (mhi_q <<< 32) + mlo_q;
    var1q_d = vfull[80:23];
    fmlo_d  = $signed({1'b0, f_q[31:0]}) * 24'sd3200000;
    fmhi_d  = $signed(f_q[63:32]) * 24'sd3200000;

    num          = (fmhi_q <<< 32) + fmlo_q;
    item_d.temp  = temp8_q;
    item_d.un    = num[87] ? bsc_pkg::UN_W'(-num) : bsc_pkg::UN_W'(num);
    item_d.ud    = var1q_q[57] ? bsc_pkg::UD_W'(-var1q_q) : bsc_pkg::UD_W'(var1q_q);
    item_d.neg   = num[87] ^ var1q_q[57];
    item_d.fault = (var1q_q == 58'sd0);
  end

  always_ff @(posedge clk_i) begin
    d_q     <= d_d;
    adcp1_q <= in_i.raw_pressure;
    dt2_q   <= dt2_d;
    dsq_q   <= dsq_d;
    adcp2_q <= adcp1_q;
    n_q     <= n_d;
    adcp3_q <= adcp2_q;
    temp4_q <= temp4_d;
    a4_q    <= a4_d;
    adcp4_q <= adcp3_q;
    aa_q    <= aa_d;
    ap5_q   <= ap5_d;
    ap2_q   <= ap2_d;
    ap3_q   <= ap3_d;
    a5_q    <= a4_q;
    temp5_q <= temp4_q;
    adcp5_q <= adcp4_q;
    e_q     <= e_d;
    dd_q    <= dd_d;
    temp6_q <= temp5_q;
    adcp6_q <= adcp5_q;
    f_q     <= f_d;
    mlo_q   <= mlo_d;
    mhi_q   <= mhi_d;
    temp7_q <= temp6_q;
    var1q_q <= var1q_d;
    fmlo_q  <= fmlo_d;
    fmhi_q  <= fmhi_d;
    temp8_q <= temp7_q;
    item_q  <= item_d;
  end

  assign push_o = v_q[8];
  assign item_o = item_q;

endmodule

/* design/bsc_fifo.sv */
// ----------------------------------------------------------------------------
// Barometric compensation queue
// Short register queue between the front end and the divider.
// ----------------------------------------------------------------------------
module bsc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bsc_pkg::fifo_item_t item_i,
  input  logic                pop_i,
  output logic                valid_o,
  output logic                full_o,
  output bsc_pkg::fifo_item_t item_o
);

  bsc_pkg::fifo_item_t mem_q [bsc_pkg::FIFO_DEPTH];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'(bsc_pkg::FIFO_DEPTH));
  assign item_o  = mem_q[rptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

/* design/bsc_div.sv */
// ----------------------------------------------------------------------------
// Barometric compensation divider
// Pipelined restoring divider, one quotient bit per stage, flooring and limit.
// ----------------------------------------------------------------------------
module bsc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  bsc_pkg::fifo_item_t item_i,
  output logic                valid_o,
  output bsc_pkg::pq_item_t   item_o
);

  localparam int unsigned NS = bsc_pkg::DIV_STEPS;

  logic [NS:0]          vld_q;
  bsc_pkg::div_stage_t  st_q [NS+1];
  bsc_pkg::div_stage_t  st0_d;
  logic [bsc_pkg::PQ_W-1:0] mag, mag_sat;
  logic                 out_vld_q;
  bsc_pkg::pq_item_t    out_q, out_d;

  always_comb begin
    st0_d.rem   = bsc_pkg::UD_W'(item_i.un[bsc_pkg::UN_W-1:NS]);
    st0_d.unl   = item_i.un[NS-1:0];
    st0_d.q     = '0;
    st0_d.ud    = item_i.ud;
    st0_d.neg   = item_i.neg;
    // A quotient of 2^41 or more is past the limit anyway.
    st0_d.ovf   = (bsc_pkg::UD_W+NS)'(item_i.un) >= {item_i.ud, {NS{1'b0}}};
    st0_d.fault = item_i.fault;
    st0_d.temp  = item_i.temp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= st0_d;
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [bsc_pkg::UD_W:0] r2;
    logic                   ge;
    bsc_pkg::div_stage_t    st_d;

    always_comb begin
      r2       = {st_q[k].rem, st_q[k].unl[NS-1]};
      ge       = (r2 >= {1'b0, st_q[k].ud});
      st_d     = st_q[k];
      st_d.rem = ge ? bsc_pkg::UD_W'(r2 - {1'b0, st_q[k].ud})
                    : r2[bsc_pkg::UD_W-1:0];
      st_d.unl = {st_q[k].unl[NS-2:0], 1'b0};
      st_d.q   = {st_q[k].q[NS-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k+1] <= st_d;
    end
  end

  always_comb begin
    // Floor of a negative quotient rounds the magnitude up.
    mag = {1'b0, st_q[NS].q}
        + bsc_pkg::PQ_W'(st_q[NS].neg && (st_q[NS].rem != '0));
    if (st_q[NS].ovf || (mag > bsc_pkg::PQ_LIMIT)) begin
      mag_sat = bsc_pkg::PQ_LIMIT;
    end else begin
      mag_sat = mag;
    end
    out_d.pq    = st_q[NS].neg ? $signed(-mag_sat) : $signed(mag_sat);
    out_d.fault = st_q[NS].fault;
    out_d.temp  = st_q[NS].temp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = out_vld_q;
  assign item_o  = out_q;

endmodule

/* design/bsc_post.sv */
// ----------------------------------------------------------------------------
// Barometric compensation pressure correction
// Second-order correction of the pressure, clamping and result register.
// ----------------------------------------------------------------------------
module bsc_post (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  bsc_pkg::pq_item_t  item_i,
  input  bsc_pkg::coeff_t    coeff_i,
  output logic               valid_o,
  output bsc_pkg::out_item_t res_o
);

  logic [3:0] v_q;

  logic signed [57:0]  x_q, x_d, s8_q, s8_d, s8b_q;
  logic signed [41:0]  pq1_q, pq2_q;
  logic signed [79:0]  ylo_q, ylo_d;
  logic signed [78:0]  yhi_q, yhi_d;
  logic signed [103:0] sum_q, sum_d;
  logic signed [60:0]  s;
  logic                fault1_q, fault2_q, fault3_q;
  logic signed [15:0]  temp1_q, temp2_q, temp3_q;
  bsc_pkg::out_item_t  res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_comb begin
    x_d  = $signed(coeff_i.p9) * item_i.pq;
    s8_d = item_i.pq * $signed(coeff_i.p8);

    ylo_d = x_q * $signed({1'b0, pq1_q[20:0]});
    yhi_d = x_q * $signed(pq1_q[41:21]);

    sum_d = (yhi_q <<< 21) + ylo_q + (pq2_q <<< 43) + (s8b_q <<< 24)
          + ($signed(coeff_i.p7) <<< 47);

    s = sum_q[103:43];
    res_d.temperature_centi_c = temp3_q;
    res_d.divide_fault        = fault3_q;
    if (fault3_q || s[60]) begin
      res_d.pressure_q24_8 = 32'd0;
    end else if (s[59:32] != 28'd0) begin
      res_d.pressure_q24_8 = 32'hffff_ffff;
    end else begin
      res_d.pressure_q24_8 = s[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    s8_q     <= s8_d;
    pq1_q    <= item_i.pq;
    fault1_q <= item_i.fault;
    temp1_q  <= item_i.temp;
    ylo_q    <= ylo_d;
    yhi_q    <= yhi_d;
    s8b_q    <= s8_q;
    pq2_q    <= pq1_q;
    fault2_q <= fault1_q;
    temp2_q  <= temp1_q;
    sum_q    <= sum_d;
    fault3_q <= fault2_q;
    temp3_q  <= temp2_q;
    res_q    <= res_d;
  end

  assign valid_o = v_q[3];
  assign res_o   = res_q;

endmodule

/* design/barometric_sensor_compensation_top.sv */
// ----------------------------------------------------------------------------
// Barometric sensor compensation
// Calibrated temperature and pressure from raw sensor readings.
// ----------------------------------------------------------------------------
// The block takes one item, a raw temperature and a raw pressure reading, in
// every clock cycle while busy_o is low and returns one result for each item,
// in order: a pulse on res_valid_o with the temperature in hundredths of a
// degree, the pressure in unsigned Q24.8 pascals and a fault flag. The
// receiver cannot hold results off, so each result is shown for exactly one
// cycle. The restoring divider resolves one quotient bit per pipeline stage
// over 41 stages, between the front end and the correction stages. busy_o
// rises only if the queue between the front end and the divider is full,
// which does not happen in normal use since the divider drains it in every
// cycle. The six coefficient registers reset to zero and must be written
// while no item is in flight; writes to an unused index are ignored.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  bsc_pkg::in_item_t                   in_i,
  input  logic                                cfg_we_i,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                res_valid_o,
  output bsc_pkg::out_item_t                  res_o
);

  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_q [bsc_pkg::NUM_REGS];
  bsc_pkg::coeff_t     coeff;
  logic                accept;
  logic                push;
  bsc_pkg::fifo_item_t front_item;
  logic                fifo_valid;
  logic                fifo_full;
  bsc_pkg::fifo_item_t fifo_item;
  logic                pq_valid;
  bsc_pkg::pq_item_t   pq_item;

  // Coefficient registers, written through the plain write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bsc_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsc_pkg::REG_T1_T2: begin
          cfg_q[0] <= cfg_data_i;
        end
        bsc_pkg::REG_T3_P1: begin
          cfg_q[1] <= cfg_data_i;
        end
        bsc_pkg::REG_P2_P3: begin
          cfg_q[2] <= cfg_data_i;
        end
        bsc_pkg::REG_P4_P5: begin
          cfg_q[3] <= cfg_data_i;
        end
        bsc_pkg::REG_P6_P7: begin
          cfg_q[4] <= cfg_data_i;
        end
        bsc_pkg::REG_P8_P9: begin
          cfg_q[5] <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Unpack the coefficients into their fields.
  always_comb begin
    coeff.t1 = cfg_q[0][15:0];
    coeff.t2 = $signed(cfg_q[0][31:16]);
    coeff.t3 = $signed(cfg_q[1][15:0]);
    coeff.p1 = cfg_q[1][31:16];
    coeff.p2 = $signed(cfg_q[2][15:0]);
    coeff.p3 = $signed(cfg_q[2][31:16]);
    coeff.p4 = $signed(cfg_q[3][15:0]);
    coeff.p5 = $signed(cfg_q[3][31:16]);
    coeff.p6 = $signed(cfg_q[4][15:0]);
    coeff.p7 = $signed(cfg_q[4][31:16]);
    coeff.p8 = $signed(cfg_q[5][15:0]);
    coeff.p9 = $signed(cfg_q[5][31:16]);
  end

  // An item is taken whenever start is high and the queue has room.
  assign busy_o = fifo_full;
  assign accept = start_i && !busy_o;

  bsc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .coeff_i  (coeff),
    .push_o   (push),
    .item_o   (front_item)
  );

  // The divider never stalls, so the queue is popped whenever it holds an item.
  bsc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (fifo_valid),
    .valid_o (fifo_valid),
    .full_o  (fifo_full),
    .item_o  (fifo_item)
  );

  bsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fifo_valid),
    .item_i  (fifo_item),
    .valid_o (pq_valid),
    .item_o  (pq_item)
  );

  bsc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pq_valid),
    .item_i  (pq_item),
    .coeff_i (coeff),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );

endmodule
